@@ sv/tzca_pkg.sv @@
// ----------------------------------------------------------------------------
// tzca_pkg
// Types, constants and helpers shared by the time zone calendar adjust block.
// ----------------------------------------------------------------------------
package tzca_pkg;

	localparam int unsigned HOURS_PER_DAY   = 24;
	localparam int unsigned MONTHS_PER_YEAR = 12;
	localparam int unsigned YEAR_LAST       = 99;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_HOURS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEASON_SHIFT = 1'b1;

	localparam logic [3:0] OFFSET_HOURS_RST = 4'd2;
	localparam logic       SEASON_SHIFT_RST = 1'b1;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;

	typedef struct packed {
		logic [5:0] in_second;
		logic [5:0] in_minute;
		logic [4:0] in_hour;
		logic [4:0] in_day;
		logic [3:0] in_month;
		logic [6:0] in_year;
		logic       season_is_winter;
	} in_item_t;

	typedef struct packed {
		logic [5:0] out_second;
		logic [5:0] out_minute;
		logic [4:0] out_hour;
		logic [4:0] out_day;
		logic [3:0] out_month;
		logic [6:0] out_year;
	} out_item_t;

	typedef struct packed {
		logic [3:0] offset_hours;
		logic       season_shift_enable;
	} cfg_t;

	// Days in a month; months outside 1..12 count as 31 days.
	function automatic logic [4:0] month_len(input logic [1:0] year_lo, input logic [3:0] month);
		logic [4:0] len;
		len = 5'd31;
		case (month)
			MONTH_FEB: len = (year_lo == 2'd0) ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ sv/tzca_if.sv @@
// ----------------------------------------------------------------------------
// tzca_if
// Valid/ready channels for UTC time requests and local time results.
// ----------------------------------------------------------------------------
interface tzca_in_if import tzca_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tzca_out_if import tzca_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/tzca_cfg.sv @@
// ----------------------------------------------------------------------------
// tzca_cfg
// Configuration registers: hour offset and seasonal shift enable.
// ----------------------------------------------------------------------------
module tzca_cfg import tzca_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	logic [3:0] offset_hours_q;
	logic       season_shift_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_hours_q        <= OFFSET_HOURS_RST;
			season_shift_enable_q <= SEASON_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_HOURS: offset_hours_q        <= cfg_data[3:0];
				REG_SEASON_SHIFT: season_shift_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.offset_hours        = offset_hours_q;
	assign cfg.season_shift_enable = season_shift_enable_q;

endmodule

@@ sv/tzca_calc.sv @@
// ----------------------------------------------------------------------------
// tzca_calc
// Adds the hour offset to a UTC timestamp and rolls over day, month, year.
// ----------------------------------------------------------------------------
module tzca_calc import tzca_pkg::*; (
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	logic [4:0] steps;
	logic [5:0] hour_sum;
	logic [4:0] hour_new;
	logic       day_adv;
	logic [5:0] day_inc;
	logic [4:0] mlen;
	logic       month_adv;
	logic [4:0] month_inc;
	logic       year_adv;
	logic [4:0] day_new;
	logic [3:0] month_new;
	logic [6:0] year_new;

	assign steps    = {1'b0, cfg.offset_hours}
			+ {4'd0, item.season_is_winter & cfg.season_shift_enable};
	assign hour_sum = {1'b0, item.in_hour} + {1'b0, steps};

	// Offset is at most 16 hours, so there is at most one day rollover.
	always_comb begin
		hour_new = item.in_hour;
		day_adv  = 1'b0;
		if (steps != 5'd0) begin
			if (item.in_hour >= 5'(HOURS_PER_DAY)) begin
				// out-of-range hour wraps on the first step
				hour_new = steps - 5'd1;
				day_adv  = 1'b1;
			end else if (hour_sum >= 6'(HOURS_PER_DAY)) begin
				hour_new = 5'(hour_sum - 6'(HOURS_PER_DAY));
				day_adv  = 1'b1;
			end else begin
				hour_new = hour_sum[4:0];
			end
		end
	end

	assign mlen      = month_len(item.in_year[1:0], item.in_month);
	assign day_inc   = {1'b0, item.in_day} + 6'd1;
	assign month_adv = day_adv && (day_inc > {1'b0, mlen});
	assign month_inc = {1'b0, item.in_month} + 5'd1;
	assign year_adv  = month_adv && (month_inc > 5'(MONTHS_PER_YEAR));

	always_comb begin
		day_new   = item.in_day;
		month_new = item.in_month;
		year_new  = item.in_year;
		if (day_adv) begin
			day_new = month_adv ? 5'd1 : day_inc[4:0];
		end
		if (month_adv) begin
			month_new = year_adv ? 4'd1 : month_inc[3:0];
		end
		if (year_adv) begin
			year_new = (item.in_year >= 7'(YEAR_LAST)) ? 7'd0 : item.in_year + 7'd1;
		end
	end

	assign res.out_second = item.in_second;
	assign res.out_minute = item.in_minute;
	assign res.out_hour   = hour_new;
	assign res.out_day    = day_new;
	assign res.out_month  = month_new;
	assign res.out_year   = year_new;

endmodule

@@ sv/time_zone_calendar_adjust.sv @@
// ----------------------------------------------------------------------------
// time_zone_calendar_adjust
// Converts a UTC date and time into local time by a configured hour offset
// with optional winter shift and calendar rollover.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   UTC time, date, season flag (in_item_t)
//  out_ch    out  valid/ready   local time and date (out_item_t)
//  cfg_*     in   write enable  offset_hours, season_shift_enable
//
//  One request per cycle while out_ch is not stalled; each result passes the input
//  register, then the result register behind the offset/rollover logic, before it
//  is on out_ch.
//  arst_n clears both stage valids and restores register defaults.
//  A stalled output holds its result; in_ch keeps accepting while the input
//  stage can move forward or is empty.
// ----------------------------------------------------------------------------
module time_zone_calendar_adjust import tzca_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	tzca_in_if.sink                in_ch,
	tzca_out_if.source             out_ch
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_comb;
	out_item_t res_s2;
	logic      valid_s2;
	logic      ready_s1;
	logic      ready_s2;

	tzca_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tzca_calc u_calc (
		.item (item_s1),
		.cfg  (cfg),
		.res  (res_comb)
	);

	assign ready_s2    = !valid_s2 || out_ch.ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign in_ch.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_ch.valid) begin
			item_s1 <= in_ch.data;
		end
		if (ready_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

endmodule
